[rtl/atwm_pkg.sv]
// Shared types, constants and helpers for the alarm table weekday matcher.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package atwm_pkg;

  // Default table depth
  localparam int NUM_SLOTS_DEF = 16;

  // Field widths of the input and result words
  localparam int OPCODE_W = 2;
  localparam int SLOT_IN_W = 4;
  localparam int WORD_W = 16;
  localparam int DOM_W = 5;
  localparam int DOW_W = 3;
  localparam int HOUR_W = 5;
  localparam int MIN_W = 6;
  localparam int RING_W = 7;
  localparam int WDAY_W = 7;
  localparam int DAY_MEM_W = 8;

  // Day register after reset: never equal to a real day number
  localparam logic [DAY_MEM_W-1:0] DAY_NONE = 8'hFF;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_DELETE = 2'd1,
    OP_POLL   = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_t;

  // One table entry as stored in the memory
  typedef struct packed {
    logic [MIN_W-1:0]  minute;
    logic [HOUR_W-1:0] hour;
    logic              enable;
    logic              rpt;
    logic [WDAY_W-1:0] weekdays;
    logic [RING_W-1:0] ringtone;
  } slot_t;

  // Unpack the two write words into an entry
  function automatic slot_t unpack_slot(input logic [WORD_W-1:0] word_high,
                                        input logic [WORD_W-1:0] word_low);
    slot_t s;
    s.minute   = word_high[5:0];
    s.hour     = word_high[10:6];
    s.enable   = word_low[0];
    s.rpt      = word_low[1];
    s.weekdays = word_low[8:2];
    s.ringtone = word_low[15:9];
    return s;
  endfunction

  // Weekday to mask bit: Sunday (0, also 7) is the top bit, else bit w-1
  function automatic logic [WDAY_W-1:0] weekday_mask(input logic [DOW_W-1:0] dow);
    logic [DOW_W-1:0] b;
    b = dow - 3'd1;
    if (dow == 3'd0 || dow == 3'd7) begin
      return 7'b1000000;
    end
    return 7'b0000001 << b;
  endfunction

endpackage

`default_nettype wire

[rtl/atwm_if.sv]
// Valid/ready channel interfaces for the alarm table weekday matcher.
// Depends on atwm_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface atwm_in_if;
  logic                                valid;
  logic                                ready;
  logic [atwm_pkg::OPCODE_W-1:0]       opcode;
  logic [atwm_pkg::SLOT_IN_W-1:0]      slot;
  logic [atwm_pkg::WORD_W-1:0]         word_high;
  logic [atwm_pkg::WORD_W-1:0]         word_low;
  logic [atwm_pkg::DOM_W-1:0]          day_of_month;
  logic [atwm_pkg::DOW_W-1:0]          day_of_week;
  logic [atwm_pkg::HOUR_W-1:0]         now_hours;
  logic [atwm_pkg::MIN_W-1:0]          now_minutes;

  modport source (output valid, opcode, slot, word_high, word_low, day_of_month,
                  day_of_week, now_hours, now_minutes, input ready);
  modport sink (input valid, opcode, slot, word_high, word_low, day_of_month,
                day_of_week, now_hours, now_minutes, output ready);
endinterface

interface atwm_out_if;
  logic                           valid;
  logic                           ready;
  logic [atwm_pkg::SLOT_IN_W-1:0] fired_slot;
  logic [atwm_pkg::RING_W-1:0]    ringtone;
  logic                           one_shot_disabled;
  logic                           last_of_poll;

  modport source (output valid, fired_slot, ringtone, one_shot_disabled, last_of_poll,
                  input ready);
  modport sink (input valid, fired_slot, ringtone, one_shot_disabled, last_of_poll,
                output ready);
endinterface

`default_nettype wire

[rtl/alarm_table_weekday_matcher.sv]
// Alarm table with weekday matching: slot memory, poll walker, result queue.
// Depends on atwm_pkg and the channel interfaces in atwm_if.sv.
//
// Usage:
//   in_ch carries one command word per handshake. A write word unpacks
//   word_high/word_low into a slot, a delete word clears a slot, a poll word
//   carries the current date and time. Writes and deletes give no result;
//   an unused opcode is dropped.
//   A poll walks all NUM_SLOTS entries of the slot memory, one read per
//   cycle unless the walk holds, and returns one out_ch word per fired
//   slot in slot order, the final one flagged last_of_poll. A poll with
//   no match returns nothing. Each fired slot is held until the next one
//   is found or the walk ends. in_ch.ready is low for the whole walk and
//   while the last held result waits for out_ch. When out_ch stalls while
//   a held result and a new match both wait, the walk holds.
//   Reset: every slot reads as empty at once (per-slot valid flags), all
//   triggered-today marks clear and the stored day is forced to a value no
//   poll carries, so the first poll counts as a new day.
`timescale 1ns / 1ps
`default_nettype none

module alarm_table_weekday_matcher #(
  parameter int NUM_SLOTS = atwm_pkg::NUM_SLOTS_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  atwm_in_if.sink      in_ch,
  atwm_out_if.source   out_ch
);
  import atwm_pkg::*;

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int EXT_W  = 6;

  // Slot memory and per-slot flags
  slot_t              mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] valid_r;
  logic [NUM_SLOTS-1:0] trig_r;

  state_t state_r, state_nxt;

  // Walk control
  logic [CNT_W-1:0]  issue_cnt_r;
  logic              eval_v_r;
  logic [SLOT_W-1:0] eval_idx_r;
  slot_t             rd_data_r;
  logic              rd_valid_r;

  // Poll context
  logic [DAY_MEM_W-1:0] prev_day_r;
  logic [HOUR_W-1:0]    hrs_r;
  logic [MIN_W-1:0]     min_r;
  logic [WDAY_W-1:0]    wmask_r;

  // Held result, waiting to learn whether it is the last of the poll
  logic                 hold_v_r;
  logic [SLOT_IN_W-1:0] hold_slot_r;
  logic [RING_W-1:0]    hold_ring_r;
  logic                 hold_osd_r;

  // Output register
  logic                 out_valid_r;
  logic [SLOT_IN_W-1:0] out_slot_r;
  logic [RING_W-1:0]    out_ring_r;
  logic                 out_osd_r;
  logic                 out_last_r;

  // Combinational control
  logic              in_ready;
  logic              walking;
  logic              flushing;
  logic              acc;
  logic              acc_write, acc_delete, acc_poll;
  logic [EXT_W-1:0]  slot_ext;
  logic              slot_ok;
  logic [SLOT_W-1:0] cmd_addr;
  slot_t             entry;
  logic              fire;
  logic              out_free;
  logic              adv;
  logic              issue_done;
  logic              issue;
  logic              walk_end;
  logic              push_mid;
  logic              push_last;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_wa;
  slot_t             mem_wd;
  logic [SLOT_W-1:0] rd_addr;
  logic [EXT_W-1:0]  eval_ext;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc_poll) state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (walk_end) state_nxt = hold_v_r ? ST_FLUSH : ST_IDLE;
      end
      ST_FLUSH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready = 1'b0;
    walking  = 1'b0;
    flushing = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_ready = 1'b1;
      ST_WALK:  walking  = 1'b1;
      ST_FLUSH: flushing = 1'b1;
      default: ;
    endcase
  end

  assign in_ch.ready = in_ready;

  // Decode the accepted command word
  assign acc      = in_ch.valid && in_ready;
  assign slot_ext = EXT_W'(in_ch.slot);
  assign slot_ok  = slot_ext < EXT_W'(NUM_SLOTS);
  assign cmd_addr = slot_ext[SLOT_W-1:0];

  always_comb begin
    acc_write  = 1'b0;
    acc_delete = 1'b0;
    acc_poll   = 1'b0;
    unique case (opcode_t'(in_ch.opcode))
      OP_WRITE:  acc_write  = acc && slot_ok;
      OP_DELETE: acc_delete = acc && slot_ok;
      OP_POLL:   acc_poll   = acc;
      default: ;
    endcase
  end

  // Match the entry held in the read register
  assign entry = rd_valid_r ? rd_data_r : '0;
  assign fire  = eval_v_r && entry.enable && !trig_r[eval_idx_r] &&
                 entry.hour == hrs_r && entry.minute == min_r &&
                 (|(entry.weekdays & wmask_r));

  // Walk handshake: hold when a second result needs a busy output register
  assign out_free   = !out_valid_r || out_ch.ready;
  assign adv        = walking && !(fire && hold_v_r && !out_free);
  assign issue_done = issue_cnt_r == CNT_W'(NUM_SLOTS);
  assign issue      = adv && !issue_done;
  assign walk_end   = walking && issue_done && !eval_v_r;
  assign push_mid   = adv && fire && hold_v_r;
  assign push_last  = flushing && out_free;
  assign rd_addr    = issue_cnt_r[SLOT_W-1:0];
  assign eval_ext   = EXT_W'(eval_idx_r);

  // Single write port: command writes when idle, one-shot disable in the walk
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cmd_addr;
    mem_wd = unpack_slot(in_ch.word_high, in_ch.word_low);
    if (acc_write) begin
      mem_we = 1'b1;
    end else if (adv && fire && !entry.rpt) begin
      mem_we        = 1'b1;
      mem_wa        = eval_idx_r;
      mem_wd        = entry;
      mem_wd.enable = 1'b0;
    end
  end

  // Slot memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (issue) begin
      rd_data_r  <= mem[rd_addr];
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  // Control state: flags, walk counters, held and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      trig_r      <= '0;
      prev_day_r  <= DAY_NONE;
      issue_cnt_r <= '0;
      eval_v_r    <= 1'b0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc_write) begin
        valid_r[cmd_addr] <= 1'b1;
      end
      if (acc_delete) begin
        valid_r[cmd_addr] <= 1'b0;
        trig_r[cmd_addr]  <= 1'b0;
      end
      // New day: drop every triggered-today mark
      if (acc_poll) begin
        issue_cnt_r <= '0;
        if (DAY_MEM_W'(in_ch.day_of_month) != prev_day_r) begin
          trig_r     <= '0;
          prev_day_r <= DAY_MEM_W'(in_ch.day_of_month);
        end
      end
      // Advance the walk
      if (adv) begin
        eval_v_r <= issue;
        if (issue) issue_cnt_r <= issue_cnt_r + 1'b1;
        if (fire) begin
          trig_r[eval_idx_r] <= 1'b1;
          hold_v_r           <= 1'b1;
        end
      end
      if (push_last) begin
        hold_v_r <= 1'b0;
      end
      if (push_mid || push_last) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (acc_poll) begin
      hrs_r   <= in_ch.now_hours;
      min_r   <= in_ch.now_minutes;
      wmask_r <= weekday_mask(in_ch.day_of_week);
    end
    if (issue) begin
      eval_idx_r <= rd_addr;
    end
    if (adv && fire) begin
      hold_slot_r <= eval_ext[SLOT_IN_W-1:0];
      hold_ring_r <= entry.ringtone;
      hold_osd_r  <= !entry.rpt;
    end
    if (push_mid || push_last) begin
      out_slot_r <= hold_slot_r;
      out_ring_r <= hold_ring_r;
      out_osd_r  <= hold_osd_r;
      out_last_r <= push_last;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.fired_slot        = out_slot_r;
  assign out_ch.ringtone          = out_ring_r;
  assign out_ch.one_shot_disabled = out_osd_r;
  assign out_ch.last_of_poll      = out_last_r;

  // Nothing may be held back once the block is ready for a new word
  a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !hold_v_r)
    else $error("held result left over outside a poll");

  // A pending evaluation exists only during the walk
  a_eval_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    eval_v_r |-> walking)
    else $error("slot evaluation outside the walk");

  // The final push of a poll shows up flagged last
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    push_last |=> out_ch.valid && out_ch.last_of_poll)
    else $error("final result of a poll not flagged last");

  // Walk counter never passes the table depth
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    issue_cnt_r <= CNT_W'(NUM_SLOTS))
    else $error("walk counter beyond table depth");

  // A mid-poll push never carries the last flag
  a_mid_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    push_mid |=> out_ch.valid && !out_ch.last_of_poll)
    else $error("intermediate result flagged last");

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for alarm_table_weekday_matcher: drives command words and
// predicts every fired alarm. Depends on atwm_pkg and the channel interfaces in atwm_if.sv.
`timescale 1ns / 1ps

module tb;
  import atwm_pkg::*;

  localparam int NUM_SLOTS = NUM_SLOTS_DEF;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = NUM_SLOTS + 8;

  // One command word as sent on in_ch
  typedef struct {
    logic [OPCODE_W-1:0]  opcode;
    logic [SLOT_IN_W-1:0] slot;
    logic [WORD_W-1:0]    word_high;
    logic [WORD_W-1:0]    word_low;
    logic [DOM_W-1:0]     day_of_month;
    logic [DOW_W-1:0]     day_of_week;
    logic [HOUR_W-1:0]    now_hours;
    logic [MIN_W-1:0]     now_minutes;
  } cmd_t;

  // One alarm entry of the shadow table
  typedef struct {
    logic [MIN_W-1:0]  minute;
    logic [HOUR_W-1:0] hour;
    logic              enable;
    logic              rpt;
    logic [WDAY_W-1:0] weekdays;
    logic [RING_W-1:0] ringtone;
    logic              triggered;
  } alarm_entry_t;

  // One fired alarm as returned on out_ch
  typedef struct {
    logic [SLOT_IN_W-1:0] fired_slot;
    logic [RING_W-1:0]    ringtone;
    logic                 one_shot_disabled;
    logic                 last_of_poll;
  } fire_t;

  logic clk;
  logic rst_n;

  atwm_in_if  in_ch ();
  atwm_out_if out_ch ();

  alarm_table_weekday_matcher #(
    .NUM_SLOTS(NUM_SLOTS)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  alarm_entry_t     alarms [NUM_SLOTS];
  logic [DAY_MEM_W-1:0] day_seen;
  fire_t            pending_fires [$];
  fire_t            want;
  int               mismatches = 0;
  int               quiet_cycles = 0;
  int               src_idle_pct = 0;
  int               sink_stall_pct = 0;

  // Clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Receiver: stall at random, change ready on the falling edge
  initial out_ch.ready = 1'b0;
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Update the shadow table with one accepted word and queue the alarms it fires
  function automatic void apply_word(input cmd_t c);
    int bit_idx;
    int first;
    fire_t f;
    first = pending_fires.size();
    case (c.opcode)
      OP_WRITE: begin
        if (c.slot < NUM_SLOTS) begin
          alarms[c.slot].minute   = c.word_high[5:0];
          alarms[c.slot].hour     = c.word_high[10:6];
          alarms[c.slot].enable   = c.word_low[0];
          alarms[c.slot].rpt      = c.word_low[1];
          alarms[c.slot].weekdays = c.word_low[8:2];
          alarms[c.slot].ringtone = c.word_low[15:9];
        end
      end
      OP_DELETE: begin
        if (c.slot < NUM_SLOTS) alarms[c.slot] = '{default: '0};
      end
      OP_POLL: begin
        // New day: clear every triggered-today mark
        if ({3'b000, c.day_of_month} != day_seen) begin
          for (int i = 0; i < NUM_SLOTS; i++) alarms[i].triggered = 1'b0;
          day_seen = {3'b000, c.day_of_month};
        end
        bit_idx = (c.day_of_week == 3'd0 || c.day_of_week == 3'd7) ? 6 : c.day_of_week - 1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (alarms[i].enable && !alarms[i].triggered &&
              alarms[i].hour == c.now_hours && alarms[i].minute == c.now_minutes &&
              alarms[i].weekdays[bit_idx] && pending_fires.size() - first < 16) begin
            alarms[i].triggered = 1'b1;
            f.fired_slot = i[SLOT_IN_W-1:0];
            f.ringtone = alarms[i].ringtone;
            f.one_shot_disabled = !alarms[i].rpt;
            f.last_of_poll = 1'b0;
            if (!alarms[i].rpt) alarms[i].enable = 1'b0;
            pending_fires.push_back(f);
          end
        end
        if (pending_fires.size() > first) pending_fires[$].last_of_poll = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // Compare each accepted result word with the oldest expected alarm
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_fires.size() == 0) begin
        $error("unexpected result: fired_slot %0d ringtone %0d", out_ch.fired_slot,
               out_ch.ringtone);
        mismatches++;
      end else begin
        want = pending_fires.pop_front();
        if (out_ch.fired_slot !== want.fired_slot) begin
          $error("fired_slot: expected %0d, got %0d", want.fired_slot, out_ch.fired_slot);
          mismatches++;
        end
        if (out_ch.ringtone !== want.ringtone) begin
          $error("ringtone: expected %0d, got %0d", want.ringtone, out_ch.ringtone);
          mismatches++;
        end
        if (out_ch.one_shot_disabled !== want.one_shot_disabled) begin
          $error("one_shot_disabled: expected %0b, got %0b", want.one_shot_disabled,
                 out_ch.one_shot_disabled);
          mismatches++;
        end
        if (out_ch.last_of_poll !== want.last_of_poll) begin
          $error("last_of_poll: expected %0b, got %0b", want.last_of_poll,
                 out_ch.last_of_poll);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Send one word: idle at random, hold it until accepted, then predict
  task automatic send_word(input cmd_t c);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.opcode       = c.opcode;
    in_ch.slot         = c.slot;
    in_ch.word_high    = c.word_high;
    in_ch.word_low     = c.word_low;
    in_ch.day_of_month = c.day_of_month;
    in_ch.day_of_week  = c.day_of_week;
    in_ch.now_hours    = c.now_hours;
    in_ch.now_minutes  = c.now_minutes;
    in_ch.valid        = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    apply_word(c);
  endtask

  // Drop valid and hold until every expected alarm is back
  task automatic wait_drained(input int tail);
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_fires.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  function automatic cmd_t mk_write(input int slot, input int minute, input int hour,
                                    input int id, input bit en, input bit rpt,
                                    input int mask, input int ring);
    cmd_t c;
    c = '{default: '0};
    c.opcode = OP_WRITE;
    c.slot = SLOT_IN_W'(slot);
    c.word_high = {id[4:0], hour[4:0], minute[5:0]};
    c.word_low = {ring[6:0], mask[6:0], rpt, en};
    return c;
  endfunction

  function automatic cmd_t mk_poll(input int day, input int dow, input int hour,
                                   input int minute);
    cmd_t c;
    c = '{default: '0};
    c.opcode = OP_POLL;
    c.day_of_month = DOM_W'(day);
    c.day_of_week = DOW_W'(dow);
    c.now_hours = HOUR_W'(hour);
    c.now_minutes = MIN_W'(minute);
    return c;
  endfunction

  // Alarm times that random writes and polls share, so that polls hit
  function automatic int pick_hour();
    case ($urandom_range(3))
      0: return 0;
      1: return 7;
      2: return 23;
      default: return 31;
    endcase
  endfunction

  function automatic int pick_minute();
    case ($urandom_range(3))
      0: return 0;
      1: return 30;
      2: return 59;
      default: return 63;
    endcase
  endfunction

  // Basic firing: one-shot, repeat, keep mark on rewrite, new day, unused opcode
  task automatic test_basic_alarms();
    cmd_t c;
    send_word(mk_poll(31, 7, 31, 63));
    send_word(mk_write(0, 0, 0, 31, 1'b1, 1'b0, 'h7F, 0));
    send_word(mk_write(15, 59, 23, 0, 1'b1, 1'b1, 'h7F, 127));
    send_word(mk_poll(1, 0, 0, 0));
    send_word(mk_poll(1, 3, 23, 59));
    send_word(mk_write(15, 59, 23, 0, 1'b1, 1'b1, 'h7F, 127));
    send_word(mk_poll(1, 3, 23, 59));
    c = mk_write(0, 63, 31, 31, 1'b1, 1'b1, 'h7F, 127);
    c.opcode = OP_UNUSED;
    c.day_of_month = 5'd2;
    c.day_of_week = 3'd3;
    c.now_hours = 5'd23;
    c.now_minutes = 6'd59;
    send_word(c);
    send_word(mk_poll(2, 3, 23, 59));
  endtask

  // Full table: every slot fires on one poll, then delete and one-shot disabling
  task automatic test_full_table();
    cmd_t c;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      send_word(mk_write(s, 63, 31, s, 1'b1, s[0], 'h40, s * 8 + 3));
    end
    send_word(mk_poll(0, 7, 31, 63));
    c = '{default: '0};
    c.opcode = OP_DELETE;
    c.slot = 4'd5;
    send_word(c);
    send_word(mk_poll(31, 0, 31, 63));
  endtask

  // Random traffic: write, delete and poll around shared alarm times, plus noise
  task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                     input int n_items, input bit hold_off);
    cmd_t c;
    int n;
    int r;
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    n = 0;
    while (n < n_items) begin
      if (hold_off && n == n_items / 2) wait_drained(NUM_SLOTS + 4);
      c.slot = SLOT_IN_W'($urandom_range(15));
      c.word_high = WORD_W'($urandom_range(16'hFFFF));
      c.word_low = WORD_W'($urandom_range(16'hFFFF));
      c.day_of_month = DOM_W'($urandom_range(31));
      c.day_of_week = DOW_W'($urandom_range(7));
      c.now_hours = HOUR_W'($urandom_range(31));
      c.now_minutes = MIN_W'($urandom_range(63));
      r = $urandom_range(99);
      if (r < 5) begin
        c.opcode = OP_UNUSED;
      end else if (r < 45) begin
        c.opcode = OP_WRITE;
        if ($urandom_range(9) != 0) c.word_high[5:0] = MIN_W'(pick_minute());
        if ($urandom_range(9) != 0) c.word_high[10:6] = HOUR_W'(pick_hour());
        c.word_low[0] = ($urandom_range(99) < 85);
        c.word_low[8:2] = WDAY_W'($urandom_range(127) | $urandom_range(127));
        n++;
      end else if (r < 55) begin
        c.opcode = OP_DELETE;
        n++;
      end else begin
        c.opcode = OP_POLL;
        if ($urandom_range(9) != 0) c.day_of_month = DOM_W'($urandom_range(2));
        if ($urandom_range(99) < 85) begin
          c.now_hours = HOUR_W'(pick_hour());
          c.now_minutes = MIN_W'(pick_minute());
        end
        n++;
      end
      send_word(c);
    end
  endtask

  initial begin
    // Hold reset with every input at a known value
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_WRITE;
    in_ch.slot = '0;
    in_ch.word_high = '0;
    in_ch.word_low = '0;
    in_ch.day_of_month = '0;
    in_ch.day_of_week = '0;
    in_ch.now_hours = '0;
    in_ch.now_minutes = '0;
    for (int i = 0; i < NUM_SLOTS; i++) alarms[i] = '{default: '0};
    day_seen = DAY_NONE;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_basic_alarms();
    test_full_table();
    test_random_traffic(6, 73, 30, 1'b1);
    test_random_traffic(73, 6, 30, 1'b0);
    test_random_traffic(0, 0, 30, 1'b0);

    // Drain the remaining alarms, then watch for strays
    wait_drained(DRAIN_CYCLES);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
